>>> rtl/flpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flpd_pkg: shared types and constants of the line patch decoder
// Phase codes, configuration indexes, reset values and the beat struct that
// travels from the decode core to the output register.
// ----------------------------------------------------------------------------
package flpd_pkg;

    localparam int ADDR_BITS_DEF = 24;

    localparam int BYTE_W   = 8;
    localparam int WADDR_W  = 24;
    localparam int STRIDE_W = 16;
    localparam int BPP_W    = 3;
    localparam int FIELD_W  = 32;
    localparam int RUNS_W   = 16;
    localparam int COPY_W   = 18;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd1;

    localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 16'd3072;
    localparam logic [BPP_W-1:0]    BPP_RST         = 3'd3;
    localparam logic [BPP_W-1:0]    BPP_MAX         = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BASE  = 3'd1,
        PH_START = 3'd2,
        PH_COUNT = 3'd3,
        PH_RUNS  = 3'd4,
        PH_SKIP  = 3'd5,
        PH_COPYL = 3'd6,
        PH_DATA  = 3'd7
    } t_phase;

    typedef struct packed {
        logic               vld;
        logic [WADDR_W-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } t_beat;

    // Clamp the pixel size; sizes above four act as four.
    function automatic logic [BPP_W-1:0] pixel_bytes(input logic [BPP_W-1:0] bpp);
        pixel_bytes = (bpp > BPP_MAX) ? BPP_MAX : bpp;
    endfunction

endpackage
`default_nettype wire

>>> rtl/flpd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flpd_core: patch stream decode state and counters
// Assembles header and count fields, tracks lines, runs and copy lengths and
// forms one write beat for each copied byte.
// ----------------------------------------------------------------------------
module flpd_core
    import flpd_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic [BYTE_W-1:0]   i_byte,
    input  wire logic                i_fs,
    input  wire logic [STRIDE_W-1:0] i_line_stride,
    input  wire logic [BPP_W-1:0]    i_bpp,
    output t_beat                    o_beat
);

    localparam int PROD_W = FIELD_W + STRIDE_W;
    localparam int SCL_W  = RUNS_W + BPP_W;
    localparam int SKW    = (ADDR_BITS > SCL_W) ? ADDR_BITS : SCL_W;
    localparam int LNW    = (ADDR_BITS > STRIDE_W) ? ADDR_BITS : STRIDE_W;
    localparam int OXW    = (ADDR_BITS > WADDR_W) ? ADDR_BITS : WADDR_W;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_idx, n_idx;
    logic [FIELD_W-1:0]    r_asm, n_asm;
    logic [ADDR_BITS-1:0]  r_line_base, n_line_base;
    logic [FIELD_W-1:0]    r_lines, n_lines;
    logic [RUNS_W-1:0]     r_runs, n_runs;
    logic [COPY_W-1:0]     r_copy, n_copy;
    logic [ADDR_BITS-1:0]  r_col, n_col;

    t_phase                eff_phase;
    logic [1:0]            eff_idx;
    logic [FIELD_W-1:0]    eff_asm;
    logic [FIELD_W-1:0]    asm_new;
    logic                  hdr_field;
    logic                  field_done;
    logic [RUNS_W-1:0]     v16;
    logic [BPP_W-1:0]      pb;
    logic [SCL_W-1:0]      scaled;
    logic [COPY_W-1:0]     copy_new;
    logic [PROD_W-1:0]     start_prod;
    logic                  lines_last;
    logic                  runs_last;
    logic                  copy_last;
    logic                  end_run;
    logic                  end_line;
    logic [ADDR_BITS-1:0]  addr_sum;
    logic [OXW-1:0]        addr_ext;

    // Frame start overrides the phase and restarts field assembly.
    assign eff_phase  = i_fs ? PH_BASE : r_phase;
    assign eff_idx    = i_fs ? 2'd0 : r_idx;
    assign eff_asm    = i_fs ? '0 : r_asm;
    assign asm_new    = eff_asm | (FIELD_W'(i_byte) << {eff_idx, 3'b000});
    assign hdr_field  = (eff_phase == PH_BASE) || (eff_phase == PH_START) ||
                        (eff_phase == PH_COUNT);
    assign field_done = hdr_field ? (eff_idx == 2'd3) : (eff_idx == 2'd1);
    assign v16        = asm_new[RUNS_W-1:0];
    assign pb         = pixel_bytes(i_bpp);
    assign scaled     = SCL_W'(v16) * SCL_W'(pb);
    assign copy_new   = COPY_W'(scaled);
    assign start_prod = PROD_W'(asm_new) * PROD_W'(i_line_stride);
    assign lines_last = (r_lines == FIELD_W'(1));
    assign runs_last  = (r_runs == RUNS_W'(1));
    assign copy_last  = (r_copy == COPY_W'(1));

    // Run and line completion for the current byte.
    always_comb begin
        end_run  = 1'b0;
        end_line = 1'b0;
        case (eff_phase)
            PH_DATA: begin
                end_run = copy_last;
            end
            PH_RUNS: begin
                end_line = field_done && (v16 == '0);
            end
            PH_COPYL: begin
                end_run = field_done && (copy_new == '0);
            end
            default: begin
                end_run = 1'b0;
            end
        endcase
        if (end_run && runs_last) begin
            end_line = 1'b1;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            n_phase = eff_phase;
            if (end_line) begin
                n_phase = lines_last ? PH_IDLE : PH_RUNS;
            end else if (end_run) begin
                n_phase = PH_SKIP;
            end else begin
                case (eff_phase)
                    PH_IDLE: n_phase = PH_IDLE;
                    PH_DATA: n_phase = PH_DATA;
                    PH_BASE: n_phase = field_done ? PH_START : PH_BASE;
                    PH_START: n_phase = field_done ? PH_COUNT : PH_START;
                    PH_COUNT: begin
                        if (field_done) begin
                            n_phase = (asm_new == '0) ? PH_IDLE : PH_RUNS;
                        end
                    end
                    PH_RUNS: n_phase = field_done ? PH_SKIP : PH_RUNS;
                    PH_SKIP: n_phase = field_done ? PH_COPYL : PH_SKIP;
                    PH_COPYL: n_phase = field_done ? PH_DATA : PH_COPYL;
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Counters, field assembly and the write beat.
    assign addr_sum = r_line_base + r_col;
    assign addr_ext = OXW'(addr_sum);

    always_comb begin
        n_idx       = r_idx;
        n_asm       = r_asm;
        n_line_base = r_line_base;
        n_lines     = r_lines;
        n_runs      = r_runs;
        n_copy      = r_copy;
        n_col       = r_col;
        o_beat.vld  = 1'b0;
        o_beat.addr = addr_ext[WADDR_W-1:0];
        o_beat.data = i_byte;
        if (i_fire && (eff_phase != PH_IDLE)) begin
            if (eff_phase == PH_DATA) begin
                o_beat.vld = 1'b1;
                n_idx      = eff_idx;
                n_asm      = eff_asm;
                n_col      = r_col + ADDR_BITS'(1);
                n_copy     = r_copy - COPY_W'(1);
            end else if (!field_done) begin
                n_idx = eff_idx + 2'd1;
                n_asm = asm_new;
            end else begin
                n_idx = 2'd0;
                n_asm = '0;
                case (eff_phase)
                    PH_START: n_line_base = start_prod[ADDR_BITS-1:0];
                    PH_COUNT: n_lines = asm_new;
                    PH_RUNS: begin
                        n_runs = v16;
                        n_col  = '0;
                    end
                    PH_SKIP: n_col = ADDR_BITS'(SKW'(r_col) + SKW'(scaled));
                    PH_COPYL: n_copy = copy_new;
                    default: n_idx = 2'd0;
                endcase
            end
            if (end_run) begin
                n_runs = r_runs - RUNS_W'(1);
            end
            if (end_line) begin
                n_line_base = ADDR_BITS'(LNW'(r_line_base) + LNW'(i_line_stride));
                n_lines     = r_lines - FIELD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_idx       <= '0;
            r_asm       <= '0;
            r_line_base <= '0;
            r_lines     <= '0;
            r_runs      <= '0;
            r_copy      <= '0;
            r_col       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_asm       <= n_asm;
            r_line_base <= n_line_base;
            r_lines     <= n_lines;
            r_runs      <= n_runs;
            r_copy      <= n_copy;
            r_col       <= n_col;
        end
    end

`ifndef ASSERT_OFF
    a_copy_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_copy != '0))
        else $error("copy count empty while copying bytes");

    a_lines_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_RUNS) || (r_phase == PH_SKIP) || (r_phase == PH_COPYL) ||
         (r_phase == PH_DATA)) |-> (r_lines != '0))
        else $error("line count empty inside a line");

    a_runs_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_SKIP) || (r_phase == PH_COPYL) || (r_phase == PH_DATA))
        |-> (r_runs != '0))
        else $error("run count empty inside a run");

    a_short_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_RUNS) || (r_phase == PH_SKIP) || (r_phase == PH_COPYL) ||
         (r_phase == PH_DATA) || (r_phase == PH_IDLE)) |-> (r_idx[1] == 1'b0))
        else $error("16-bit field byte index out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/fragment_line_patch_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_line_patch_decoder: sparse line patch to frame buffer writes
// Top level with configuration registers, input register and output register.
// ----------------------------------------------------------------------------
// The decoder takes one patch byte per beat and gives one address/data write
// for every copied pixel byte; header, count, skip and length bytes give no
// write. A beat with i_frame_start high always opens a new patch header. It
// sustains one byte per clock while the output is not stalled: each byte is
// held in the input register, is decoded in a single pass through the field
// assembler and counters, and lands in the output register, which presents
// its write. Only a stalled output register slows intake; an empty input
// register still takes one byte while a finished write waits, then stalls
// until the write drains.
// Write line_stride and bytes_per_pixel only while no byte or write is in
// flight; a write in the middle of a patch takes effect at its next use.
// ----------------------------------------------------------------------------
module fragment_line_patch_decoder
    import flpd_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // patch byte channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [BYTE_W-1:0]     i_byte_value,
    input  wire logic                  i_frame_start,
    // write channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [WADDR_W-1:0]         o_write_addr,
    output logic [BYTE_W-1:0]          o_write_data,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [STRIDE_W-1:0] r_line_stride;
    logic [BPP_W-1:0]    r_bpp;

    logic                r_in_vld, n_in_vld;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_fs;

    logic                r_out_vld, n_out_vld;
    logic [WADDR_W-1:0]  r_out_addr;
    logic [BYTE_W-1:0]   r_out_data;

    logic                out_blocked;
    logic                in_take;
    logic                fire;
    t_beat               beat;

    // Configuration: always ready, one register per beat.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_stride <= LINE_STRIDE_RST;
            r_bpp         <= BPP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_STRIDE:     r_line_stride <= i_cfg_data;
                CFG_BYTES_PER_PIXEL: r_bpp <= i_cfg_data[BPP_W-1:0];
                default:             r_bpp <= r_bpp;
            endcase
        end
    end

    // The held byte advances unless the output register is full and stalled.
    // Hold the whole pipe in that case; otherwise take a byte every cycle.
    assign out_blocked = r_out_vld && i_out_stall;
    assign fire        = r_in_vld && !out_blocked;
    assign o_in_stall  = r_in_vld && out_blocked;
    assign in_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_take) begin
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_value;
            r_in_fs   <= i_frame_start;
        end
    end

    flpd_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_byte        (r_in_byte),
        .i_fs          (r_in_fs),
        .i_line_stride (r_line_stride),
        .i_bpp         (r_bpp),
        .o_beat        (beat)
    );

    // Output register: refill whenever it is empty or being drained.
    always_comb begin
        n_out_vld = r_out_vld;
        if (!out_blocked) begin
            n_out_vld = beat.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_blocked && beat.vld) begin
            r_out_addr <= beat.addr;
            r_out_data <= beat.data;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_write_addr = r_out_addr;
    assign o_write_data = r_out_data;

`ifndef ASSERT_OFF
    a_fire_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !in_take) |=> !r_in_vld)
        else $error("input register kept a byte that was decoded");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_blocked |=> r_out_vld)
        else $error("stalled write dropped from output register");

    a_beat_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat.vld |-> fire)
        else $error("write beat formed without a decoded byte");
`endif

endmodule
`default_nettype wire
